@@ src/urs_pkg.sv @@
// Package for the ultrasonic range sampler: payload structs, phase enum,
// configuration struct, register indexes and timing constants.
// No dependencies.
package urs_pkg;

  localparam int unsigned IntervalW = 17;
  localparam int unsigned TimeoutW  = 15;
  localparam int unsigned CfgDataW  = 17;
  localparam int unsigned CmW       = 9;
  localparam int unsigned SubW      = 6;

  localparam logic [IntervalW-1:0] IntervalReset = 17'd60000;
  localparam logic [TimeoutW-1:0]  TimeoutReset  = 15'd25000;
  localparam logic [IntervalW-1:0] SinceMax      = 17'd131071;

  localparam logic [CmW-1:0]      CmMax      = 9'd400;
  localparam logic [CmW-1:0]      CmMin      = 9'd2;
  localparam logic [SubW-1:0]     UsPerCm    = 6'd58;
  localparam logic [TimeoutW-1:0] TrigLowUs  = 15'd2;
  localparam logic [TimeoutW-1:0] TrigHighUs = 15'd10;

  // Register indexes on the configuration port
  localparam logic RegInterval = 1'b0;
  localparam logic RegTimeout  = 1'b1;

  // Input operation codes
  localparam logic OpTick = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_TRIG_LOW  = 3'd1,
    PH_TRIG_HIGH = 3'd2,
    PH_WAIT_LOW  = 3'd3,
    PH_WAIT_HIGH = 3'd4,
    PH_MEASURE   = 3'd5
  } phase_e;

  typedef struct packed {
    logic op;
    logic echo_level;
  } in_item_t;

  typedef struct packed {
    logic           trigger_level;
    logic [CmW-1:0] distance_cm;
    logic           fresh;
    logic           busy_res;
  } out_item_t;

  typedef struct packed {
    logic [IntervalW-1:0] interval_us;
    logic [TimeoutW-1:0]  timeout_us;
  } cfg_t;

endpackage

@@ src/urs_pipe_reg.sv @@
// Valid/ready register slice for one payload type.
// Depends on nothing but its type parameter.
module urs_pipe_reg #(
  parameter type T = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  T     data_i,
  output logic valid_o,
  input  logic ready_i,
  output T     data_o
);

  logic valid_q;
  T     data_q;

  // Take a new transaction when empty or when the held one leaves.
  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/urs_core.sv @@
// Measurement sequencer of the ultrasonic range sampler: phase state,
// counters and distance cache, one item applied per step. Uses urs_pkg.
module urs_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  urs_pkg::in_item_t  item_i,
  input  urs_pkg::cfg_t      cfg_i,
  output urs_pkg::out_item_t result_o
);
  import urs_pkg::*;

  phase_e               phase_q, phase_d;
  logic [IntervalW-1:0] since_q, since_d;
  logic [TimeoutW-1:0]  count_q, count_d;
  logic [SubW-1:0]      sub_q, sub_d;
  logic [CmW-1:0]       cm_q, cm_d;
  logic [CmW-1:0]       cached_q, cached_d;
  logic                 fresh;

  logic [TimeoutW-1:0]  count_inc;
  logic [SubW-1:0]      sub_inc;
  logic                 check_timeout;

  assign count_inc = count_q + 1'b1;
  assign sub_inc   = sub_q + 1'b1;

  always_comb begin
    phase_d       = phase_q;
    since_d       = since_q;
    count_d       = count_q;
    sub_d         = sub_q;
    cm_d          = cm_q;
    cached_d      = cached_q;
    fresh         = 1'b0;
    check_timeout = 1'b0;
    if (step_i) begin
      if (item_i.op == OpTick) begin
        if (since_q != SinceMax) begin
          since_d = since_q + 1'b1;
        end
        case (phase_q)
          PH_TRIG_LOW: begin
            count_d = count_inc;
            if (count_inc >= TrigLowUs) begin
              phase_d = PH_TRIG_HIGH;
              count_d = '0;
            end
          end
          PH_TRIG_HIGH: begin
            count_d = count_inc;
            if (count_inc >= TrigHighUs) begin
              phase_d = PH_WAIT_LOW;
              count_d = '0;
            end
          end
          PH_WAIT_LOW: begin
            if (!item_i.echo_level) begin
              phase_d = PH_WAIT_HIGH;
            end
            check_timeout = 1'b1;
          end
          PH_WAIT_HIGH: begin
            if (item_i.echo_level) begin
              phase_d = PH_MEASURE;
              sub_d   = SubW'(1);
              cm_d    = '0;
            end
            check_timeout = 1'b1;
          end
          PH_MEASURE: begin
            if (!item_i.echo_level) begin
              // Echo fell: close out the measurement, clamp the low end.
              cached_d = (cm_q < CmMin) ? CmMin : cm_q;
              phase_d  = PH_IDLE;
              count_d  = '0;
              fresh    = 1'b1;
            end else begin
              sub_d = sub_inc;
              if (sub_inc >= UsPerCm) begin
                sub_d = '0;
                if (cm_q < CmMax) begin
                  cm_d = cm_q + 1'b1;
                end
              end
              check_timeout = 1'b1;
            end
          end
          default: begin
          end
        endcase
        if (check_timeout) begin
          count_d = count_inc;
          if (count_inc >= cfg_i.timeout_us) begin
            cached_d = CmMax;
            phase_d  = PH_IDLE;
            count_d  = '0;
            fresh    = 1'b1;
          end
        end
      end else if (phase_q == PH_IDLE && since_q >= cfg_i.interval_us) begin
        phase_d = PH_TRIG_LOW;
        count_d = '0;
        since_d = '0;
      end
    end
  end

  // Result reflects the state after this item.
  always_comb begin
    result_o.trigger_level = (phase_d == PH_TRIG_HIGH);
    result_o.distance_cm   = cached_d;
    result_o.fresh         = fresh;
    result_o.busy_res      = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      since_q  <= '0;
      count_q  <= '0;
      sub_q    <= '0;
      cm_q     <= '0;
      cached_q <= CmMax;
    end else begin
      phase_q  <= phase_d;
      since_q  <= since_d;
      count_q  <= count_d;
      sub_q    <= sub_d;
      cm_q     <= cm_d;
      cached_q <= cached_d;
    end
  end

endmodule

@@ src/ultrasonic_range_sampler_top.sv @@
// Ultrasonic range sampler, top level. Each input transaction is either a
// one-microsecond tick carrying the sampled echo level or a read request;
// each produces exactly one result transaction with the trigger pin level,
// the cached distance in cm (400 = nothing seen), a fresh flag and a busy
// flag. A read while idle, once interval_us ticks have passed since the
// last start, launches a measurement: trigger low 2 ticks, high 10 ticks,
// then the echo high time is counted in 58-tick steps and clamped to
// 2..400 cm, or 400 after timeout_us ticks with no complete echo. Each
// transaction passes the input register, urs_core and the result register;
// one transaction is taken every cycle while the result side takes results.
// Registers must be written only while no transaction is in flight; the
// block does not enforce this. Depends on urs_pkg, urs_pipe_reg, urs_core.
module ultrasonic_range_sampler_top #(
  parameter logic [urs_pkg::IntervalW-1:0] IntervalResetP = urs_pkg::IntervalReset,
  parameter logic [urs_pkg::TimeoutW-1:0]  TimeoutResetP  = urs_pkg::TimeoutReset
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [urs_pkg::CfgDataW-1:0] cfg_data_i,
  // Input channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  urs_pkg::in_item_t           in_data_i,
  // Result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output urs_pkg::out_item_t          out_data_o
);
  import urs_pkg::*;

  cfg_t      cfg_q;
  logic      s1_valid;
  logic      s1_ready;
  in_item_t  s1_data;
  logic      s2_ready;
  logic      step;
  out_item_t result;

  // Hold the configuration registers; writes land whenever enabled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_us <= IntervalResetP;
      cfg_q.timeout_us  <= TimeoutResetP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegInterval: cfg_q.interval_us <= cfg_data_i[IntervalW-1:0];
        RegTimeout:  cfg_q.timeout_us  <= cfg_data_i[TimeoutW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register: capture the transaction ahead of the sequencer.
  urs_pipe_reg #(.T(in_item_t)) u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  // Advance the sequencer exactly when the held item moves to the result
  // register, so state and results stay in transaction order.
  assign step     = s1_valid && s2_ready;
  assign s1_ready = s2_ready;

  urs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (s1_data),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Result register: hold a finished result until it is taken.
  urs_pipe_reg #(.T(out_item_t)) u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s2_ready),
    .data_i  (result),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

@@ src/urs_checker.sv @@
// Port-level checks for the ultrasonic range sampler, bound to the top
// level. Uses urs_pkg.
module urs_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input urs_pkg::out_item_t out_data_o
);
  import urs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_fresh_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.fresh |->
      !out_data_o.busy_res && out_data_o.distance_cm >= CmMin &&
      out_data_o.distance_cm <= CmMax)
    else $error("fresh result while busy or out of range");

  a_trig_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.trigger_level |-> out_data_o.busy_res)
    else $error("trigger high outside a measurement");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid straight out of reset");

endmodule

bind ultrasonic_range_sampler_top urs_checker u_urs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
